// File: design/sgbt_pkg.sv
`default_nettype none

package sgbt_pkg;

    typedef enum logic [1:0] {
        REQ_LIVE   = 2'd0,
        REQ_SAMPLE = 2'd1,
        REQ_TICK   = 2'd2
    } t_req_type;

    localparam int SEQ_W  = 31;
    localparam int STAT_W = 32;
    localparam int ATT_W  = 4;
    localparam int TICK_W = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    typedef logic [SEQ_W-1:0]  t_seq;
    typedef logic [STAT_W-1:0] t_stat;
    typedef logic [ATT_W-1:0]  t_att;
    typedef logic [TICK_W-1:0] t_tick;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ATTEMPTS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RETRY_TICKS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BACKOFF_TICKS = 2'd2;

    localparam t_att  MAX_ATTEMPTS_RST  = 4'd6;
    localparam t_tick RETRY_TICKS_RST   = 16'd5000;
    localparam t_tick BACKOFF_TICKS_RST = 16'd8000;

endpackage

`default_nettype wire

// File: design/sequence_gap_backfill_tracker.sv
`default_nettype none

// Channel   | Direction | Handshake                | Payload
// ----------+-----------+--------------------------+------------------------------------------
// input     | in        | i_in_valid / o_in_ready  | i_req_type, i_seq_count, i_delivered
// result    | out       | o_out_valid / i_out_ready| o_send_request .. o_backfill_active
// config    | in        | i_cfg_we (no wait)       | i_cfg_idx, i_cfg_data
//
// One word in per cycle, one result word out per cycle, unless the result side stalls;
// each word passes the input register, then the state update into the result register.
// The state update is a single pass of compares and adds on the stage-one word.
// Reset is synchronous, active low, and clears all tracking state and the map.
// A stalled result register holds stage one; input ready falls only when both are full.
module sequence_gap_backfill_tracker #(
    parameter int WINDOW = 32
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_in_valid,
    output logic                                o_in_ready,
    input  sgbt_pkg::t_req_type                 i_req_type,
    input  wire  [sgbt_pkg::SEQ_W-1:0]          i_seq_count,
    input  wire                                 i_delivered,
    output logic                                o_out_valid,
    input  wire                                 i_out_ready,
    output logic                                o_send_request,
    output logic [sgbt_pkg::SEQ_W-1:0]          o_request_from,
    output logic [sgbt_pkg::SEQ_W-1:0]          o_request_to,
    output logic [sgbt_pkg::SEQ_W-1:0]          o_miss_gap,
    output logic [sgbt_pkg::STAT_W-1:0]         o_miss_total,
    output logic [sgbt_pkg::STAT_W-1:0]         o_packet_total,
    output logic                                o_counter_reset,
    output logic                                o_range_complete,
    output logic                                o_round_restarted,
    output logic                                o_backfill_active,
    input  wire                                 i_cfg_we,
    input  wire  [sgbt_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire  [sgbt_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import sgbt_pkg::*;

    localparam int GOT_W = $clog2(WINDOW + 1);

    // configuration
    t_att  r_max_attempts;
    t_tick r_retry_ticks;
    t_tick r_backoff_ticks;

    // stage one
    logic      r_s1_valid;
    t_req_type r_s1_type;
    t_seq      r_s1_seq;
    logic      r_s1_dlv;

    // tracking state
    t_seq              r_last, n_last;
    logic              r_have, n_have;
    t_seq              r_gap, n_gap;
    t_stat             r_drop, n_drop;
    t_stat             r_pkt, n_pkt;
    logic              r_open, n_open;
    t_seq              r_from, n_from;
    t_seq              r_to, n_to;
    t_att              r_att, n_att;
    logic [GOT_W-1:0]  r_got, n_got;
    logic [WINDOW-1:0] r_map, n_map;
    t_tick             r_wait, n_wait;

    logic n_send, n_creset, n_complete, n_restarted;

    logic r_out_valid;
    logic w_advance;

    // datapath helpers
    t_seq              w_gap_raw;
    logic              w_gt;
    logic [STAT_W:0]   w_pkt_sum;
    logic [STAT_W:0]   w_drop_sum;
    t_stat             w_drop_base;
    t_seq              w_idx;
    logic [WINDOW-1:0] w_sel;
    logic              w_in_win;
    logic              w_new_mark;
    logic [GOT_W-1:0]  w_got_inc;
    t_stat             w_span;

    assign w_advance  = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || w_advance;
    assign o_out_valid = r_out_valid;

    assign w_gt      = r_s1_seq > r_last;
    assign w_gap_raw = w_gt ? (r_s1_seq - r_last - SEQ_W'(1)) : '0;
    assign w_pkt_sum = {1'b0, r_pkt} + (STAT_W+1)'(1);
    assign w_span    = {1'b0, r_to - r_from} + STAT_W'(1);
    assign w_idx     = r_s1_seq - r_from;
    assign w_in_win  = r_s1_dlv && r_open && (r_s1_seq >= r_from) && (r_s1_seq <= r_to);

    always_comb begin
        for (int i = 0; i < WINDOW; i++) begin
            w_sel[i] = w_in_win && (w_idx == SEQ_W'(i));
        end
    end

    assign w_new_mark = |(w_sel & ~r_map);
    assign w_got_inc  = r_got + GOT_W'(w_new_mark);

    always_comb begin
        n_last = r_last;
        n_have = r_have;
        n_gap  = r_gap;
        n_drop = r_drop;
        n_pkt  = r_pkt;
        n_open = r_open;
        n_from = r_from;
        n_to   = r_to;
        n_att  = r_att;
        n_got  = r_got;
        n_map  = r_map;
        n_wait = r_wait;
        n_send      = 1'b0;
        n_creset    = 1'b0;
        n_complete  = 1'b0;
        n_restarted = 1'b0;
        w_drop_base = r_drop;
        w_drop_sum  = '0;

        case (r_s1_type)
            REQ_LIVE: begin
                n_pkt = w_pkt_sum[STAT_W] ? '1 : w_pkt_sum[STAT_W-1:0];
                if (!r_have) begin
                    n_have = 1'b1;
                    n_gap  = '0;
                    n_drop = '0;
                end else begin
                    if (!w_gt) begin
                        n_creset    = 1'b1;
                        w_drop_base = '0;
                    end
                    n_gap  = w_gap_raw;
                    n_drop = w_drop_base;
                    if (w_gap_raw != '0) begin
                        w_drop_sum = {1'b0, w_drop_base} + {2'b00, w_gap_raw};
                        n_drop = w_drop_sum[STAT_W] ? '1 : w_drop_sum[STAT_W-1:0];
                        // a window already open keeps its range
                        if (!r_open) begin
                            n_open = 1'b1;
                            n_from = r_last + SEQ_W'(1);
                            n_to   = r_s1_seq - SEQ_W'(1);
                            n_att  = '0;
                            n_got  = '0;
                            n_map  = '0;
                            n_wait = '0;
                        end
                    end
                end
                n_last = r_s1_seq;
            end
            REQ_SAMPLE: begin
                if (w_in_win) begin
                    n_map = r_map | w_sel;
                    n_got = w_got_inc;
                    if (STAT_W'(w_got_inc) >= w_span) begin
                        n_open     = 1'b0;
                        n_att      = '0;
                        n_got      = '0;
                        n_complete = 1'b1;
                    end
                end
            end
            REQ_TICK: begin
                if (r_open) begin
                    if (r_wait > TICK_W'(1)) begin
                        n_wait = r_wait - TICK_W'(1);
                    end else begin
                        n_wait = '0;
                        if (r_att >= r_max_attempts) begin
                            if (STAT_W'(r_got) < w_span) begin
                                n_att       = '0;
                                n_wait      = r_backoff_ticks;
                                n_restarted = 1'b1;
                            end else begin
                                n_open = 1'b0;
                            end
                        end else begin
                            n_send = 1'b1;
                            n_att  = r_att + ATT_W'(1);
                            n_wait = r_retry_ticks;
                        end
                    end
                end
            end
            default: begin
                // unused code: drop the word, report state unchanged
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_attempts  <= MAX_ATTEMPTS_RST;
            r_retry_ticks   <= RETRY_TICKS_RST;
            r_backoff_ticks <= BACKOFF_TICKS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MAX_ATTEMPTS:  r_max_attempts  <= i_cfg_data[ATT_W-1:0];
                CFG_RETRY_TICKS:   r_retry_ticks   <= i_cfg_data[TICK_W-1:0];
                CFG_BACKOFF_TICKS: r_backoff_ticks <= i_cfg_data[TICK_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_s1_type <= i_req_type;
            r_s1_seq  <= i_seq_count;
            r_s1_dlv  <= i_delivered;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last <= '0;
            r_have <= 1'b0;
            r_gap  <= '0;
            r_drop <= '0;
            r_pkt  <= '0;
            r_open <= 1'b0;
            r_from <= '0;
            r_to   <= '0;
            r_att  <= '0;
            r_got  <= '0;
            r_map  <= '0;
            r_wait <= '0;
        end else if (w_advance) begin
            r_last <= n_last;
            r_have <= n_have;
            r_gap  <= n_gap;
            r_drop <= n_drop;
            r_pkt  <= n_pkt;
            r_open <= n_open;
            r_from <= n_from;
            r_to   <= n_to;
            r_att  <= n_att;
            r_got  <= n_got;
            r_map  <= n_map;
            r_wait <= n_wait;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            o_send_request    <= n_send;
            o_request_from    <= n_open ? n_from : '0;
            o_request_to      <= n_open ? n_to : '0;
            o_miss_gap        <= n_gap;
            o_miss_total      <= n_drop;
            o_packet_total    <= n_pkt;
            o_counter_reset   <= n_creset;
            o_range_complete  <= n_complete;
            o_round_restarted <= n_restarted;
            o_backfill_active <= n_open;
        end
    end

    // map population tracks the fill count while a window is open
    a_map_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_open |-> ($countones(r_map) == int'(r_got)))
        else $error("got count disagrees with marked map entries");

    a_window_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_open |-> (r_to >= r_from))
        else $error("open window has inverted bounds");

    a_closed_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_backfill_active) |->
            (o_request_from == '0 && o_request_to == '0 && !o_send_request))
        else $error("closed window reports bounds or a request");

    a_reset_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && o_counter_reset) |-> (o_miss_gap == '0 && o_miss_total == '0))
        else $error("counter reset left drop statistics");

    a_restart_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && o_round_restarted) |-> (!o_send_request && o_backfill_active))
        else $error("backoff start with a request or closed window");

endmodule

`default_nettype wire

// File: test/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import sgbt_pkg::*;

    localparam int        WIN         = 32;
    localparam t_seq      SEQ_MAX     = '1;
    localparam t_req_type REQ_NONE    = t_req_type'(2'd3);
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int        QUIET_LIMIT = 2000;
    localparam int        HOLD_AT     = 540;
    localparam int        HOLD_CYCLES = 80;

    typedef struct packed {
        logic  send;
        t_seq  req_lo;
        t_seq  req_hi;
        t_seq  gap;
        t_stat drops;
        t_stat packets;
        logic  went_back;
        logic  filled;
        logic  restarted;
        logic  active;
    } t_result;

    typedef struct packed {
        t_req_type kind;
        t_seq      seq;
        logic      dlv;
        logic      typed;
        t_result   want;
    } t_row;

    logic      clk = 1'b0;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    t_req_type req_type;
    t_seq      seq_count;
    logic      delivered;
    logic      out_valid;
    logic      out_ready;
    logic      send_request;
    t_seq      request_from;
    t_seq      request_to;
    t_seq      miss_gap;
    t_stat     miss_total;
    t_stat     packet_total;
    logic      counter_reset;
    logic      range_complete;
    logic      round_restarted;
    logic      backfill_active;
    logic      cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    // word currently offered, with an optional hand-written expectation
    logic      row_typed;
    t_result   row_want;

    // tracker shadow state and registers
    t_att           cfg_attempts;
    t_tick          cfg_retry;
    t_tick          cfg_backoff;
    t_seq           prev_count;
    logic           have_prev;
    t_seq           gap_q;
    t_stat          drop_q;
    t_stat          packet_q;
    logic           win_open;
    t_seq           win_lo;
    t_seq           win_hi;
    t_att           tries;
    logic [5:0]     marks;
    logic [WIN-1:0] mark_map;
    t_tick          ticks_left;

    t_result result_q[$];
    t_row    stim_tab[$];
    int      errors      = 0;
    int      words_in    = 0;
    int      results_out = 0;
    int      n_sends     = 0;
    int      n_fills     = 0;
    int      n_restarts  = 0;
    int      n_backs     = 0;
    int      quiet       = 0;

    sequence_gap_backfill_tracker #(
        .WINDOW(WIN)
    ) i_dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_ready       (in_ready),
        .i_req_type       (req_type),
        .i_seq_count      (seq_count),
        .i_delivered      (delivered),
        .o_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .o_send_request   (send_request),
        .o_request_from   (request_from),
        .o_request_to     (request_to),
        .o_miss_gap       (miss_gap),
        .o_miss_total     (miss_total),
        .o_packet_total   (packet_total),
        .o_counter_reset  (counter_reset),
        .o_range_complete (range_complete),
        .o_round_restarted(round_restarted),
        .o_backfill_active(backfill_active),
        .i_cfg_we         (cfg_we),
        .i_cfg_idx        (cfg_idx),
        .i_cfg_data       (cfg_data)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    task automatic reset_tracker();
        cfg_attempts = MAX_ATTEMPTS_RST;
        cfg_retry    = RETRY_TICKS_RST;
        cfg_backoff  = BACKOFF_TICKS_RST;
        prev_count   = '0;
        have_prev    = 1'b0;
        gap_q        = '0;
        drop_q       = '0;
        packet_q     = '0;
        win_open     = 1'b0;
        win_lo       = '0;
        win_hi       = '0;
        tries        = '0;
        marks        = '0;
        mark_map     = '0;
        ticks_left   = '0;
    endtask

    function automatic t_stat sat_sum(t_stat a, t_stat b);
        logic [STAT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[STAT_W] ? '1 : s[STAT_W-1:0];
    endfunction

    function automatic t_result outcome(logic send, t_seq lo, t_seq hi, t_seq gap,
                                        t_stat drops, t_stat pkts, logic back,
                                        logic filled, logic restarted, logic active);
        t_result r;
        r = '{send, lo, hi, gap, drops, pkts, back, filled, restarted, active};
        return r;
    endfunction

    // Advance the shadow tracker by one word and return the result it produces.
    function automatic t_result track_word(t_req_type kind, t_seq seq, logic dlv);
        t_result     r;
        t_seq        g;
        t_seq        idx;
        logic [31:0] span;
        r = '0;
        case (kind)
            REQ_LIVE: begin
                packet_q = sat_sum(packet_q, 32'd1);
                if (!have_prev) begin
                    have_prev = 1'b1;
                    gap_q     = '0;
                    drop_q    = '0;
                end else begin
                    g = '0;
                    if (seq > prev_count) begin
                        g = seq - prev_count - 1'b1;
                    end else begin
                        r.went_back = 1'b1;
                        drop_q      = '0;
                    end
                    gap_q = g;
                    if (g != '0) begin
                        drop_q = sat_sum(drop_q, {1'b0, g});
                        // the range of a second gap is dropped while a window is open
                        if (!win_open) begin
                            win_open   = 1'b1;
                            win_lo     = prev_count + 1'b1;
                            win_hi     = seq - 1'b1;
                            tries      = '0;
                            marks      = '0;
                            mark_map   = '0;
                            ticks_left = '0;
                        end
                    end
                end
                prev_count = seq;
            end
            REQ_SAMPLE: begin
                if (dlv && win_open && seq >= win_lo && seq <= win_hi) begin
                    idx  = seq - win_lo;
                    span = {1'b0, win_hi} - {1'b0, win_lo} + 32'd1;
                    if (idx < WIN && !mark_map[idx[4:0]]) begin
                        mark_map[idx[4:0]] = 1'b1;
                        marks              = marks + 1'b1;
                    end
                    if ({26'd0, marks} >= span) begin
                        win_open = 1'b0;
                        tries    = '0;
                        marks    = '0;
                        r.filled = 1'b1;
                    end
                end
            end
            REQ_TICK: begin
                if (win_open) begin
                    if (ticks_left > 1) begin
                        ticks_left = ticks_left - 1'b1;
                    end else begin
                        span       = {1'b0, win_hi} - {1'b0, win_lo} + 32'd1;
                        ticks_left = '0;
                        if (tries >= cfg_attempts) begin
                            if ({26'd0, marks} < span) begin
                                tries       = '0;
                                ticks_left  = cfg_backoff;
                                r.restarted = 1'b1;
                            end else begin
                                win_open = 1'b0;
                            end
                        end else begin
                            r.send     = 1'b1;
                            tries      = tries + 1'b1;
                            ticks_left = cfg_retry;
                        end
                    end
                end
            end
            default: ;
        endcase
        r.req_lo  = win_open ? win_lo : '0;
        r.req_hi  = win_open ? win_hi : '0;
        r.gap     = gap_q;
        r.drops   = drop_q;
        r.packets = packet_q;
        r.active  = win_open;
        return r;
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] seen);
        if (seen !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, seen);
            errors++;
        end
    endtask

    // Hold the word until it is taken, then return at the next falling edge.
    task automatic send_word(t_req_type kind, t_seq seq, logic dlv, logic typed,
                             t_result want);
        req_type  = kind;
        seq_count = seq;
        delivered = dlv;
        row_typed = typed;
        row_want  = want;
        in_valid  = 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
    endtask

    // Mostly well-formed traffic: in-order packets, gaps that open a window,
    // samples that fill it, ticks that drive the retry rounds; the rest is noise.
    task automatic pick_word(input bit wide, output t_req_type kind, output t_seq seq,
                             output logic dlv);
        int unsigned roll;
        int unsigned p;
        int unsigned step;
        int unsigned span;
        int unsigned off;
        roll = $urandom_range(99);
        p    = 32'(prev_count);
        kind = REQ_TICK;
        seq  = t_seq'($urandom);
        dlv  = 1'($urandom);
        if (roll < 4) begin
            kind = REQ_NONE;
        end else if (win_open && roll < 50) begin
            kind = REQ_SAMPLE;
            dlv  = ($urandom_range(9) != 0);
            span = 32'(win_hi - win_lo) + 1;
            off  = $urandom_range((span > 48) ? 47 : span - 1);
            if ($urandom_range(1) == 1) begin
                for (int i = WIN - 1; i >= 0; i--)
                    if (i < span && !mark_map[i]) off = i;
            end
            seq = t_seq'(win_lo + off);
            if (roll >= 44)
                seq = (win_hi < SEQ_MAX && roll[0]) ? win_hi + 1'b1 : t_seq'($urandom);
        end else if (win_open ? roll < 78 : roll < 32) begin
            if (!win_open && roll < 16) kind = REQ_SAMPLE;
        end else begin
            kind = REQ_LIVE;
            roll = $urandom_range(99);
            if (roll < 12 || p == SEQ_MAX) begin
                seq = t_seq'($urandom_range(p, 0));
            end else if (win_open && roll < 32) begin
                seq = t_seq'($urandom_range(SEQ_MAX, p + 1));
            end else if (!win_open && roll < 35) begin
                step = wide ? $urandom_range(90, 34) : $urandom_range(33, 2);
                if (wide && roll < 15)
                    seq = t_seq'($urandom_range(SEQ_MAX, p + 1));
                else if (p + step > SEQ_MAX)
                    seq = t_seq'($urandom_range(p, 0));
                else
                    seq = t_seq'(p + step);
            end else begin
                seq = t_seq'(p + 1);
            end
        end
    endtask

    task automatic run_random(int n, bit wide);
        int        burst;
        t_req_type kind;
        t_seq      seq;
        logic      dlv;
        burst = 0;
        repeat (n) begin
            if (burst == 0) begin
                burst = $urandom_range(24, 1);
                if ($urandom_range(3) != 0) begin
                    in_valid = 1'b0;
                    repeat ($urandom_range(6, 1)) @(negedge clk);
                end
            end
            burst--;
            pick_word(wide, kind, seq, dlv);
            send_word(kind, seq, dlv, 1'b0, '0);
        end
    endtask

    task automatic drain();
        in_valid = 1'b0;
        while (result_q.size() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_we   = 1'b1;
        cfg_idx  = idx;
        cfg_data = data;
        case (idx)
            CFG_MAX_ATTEMPTS:  cfg_attempts = data[ATT_W-1:0];
            CFG_RETRY_TICKS:   cfg_retry    = data;
            CFG_BACKOFF_TICKS: cfg_backoff  = data;
            default: ;
        endcase
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic set_rounds(logic [CFG_DATA_W-1:0] attempts, t_tick retry, t_tick backoff);
        write_reg(CFG_MAX_ATTEMPTS, attempts);
        write_reg(CFG_RETRY_TICKS, retry);
        write_reg(CFG_BACKOFF_TICKS, backoff);
    endtask

    initial begin : receiver
        int hold_left;
        int mode;
        int phase_left;
        bit held;
        hold_left  = 0;
        mode       = 0;
        phase_left = 0;
        held       = 1'b0;
        out_ready  = 1'b0;
        forever begin
            @(negedge clk);
            // one long hold-off while the sender keeps offering words
            if (!held && words_in >= HOLD_AT) begin
                held      = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (phase_left == 0) begin
                mode       = $urandom_range(2);
                phase_left = $urandom_range(80, 20);
            end
            phase_left--;
            if (hold_left > 0) begin
                hold_left--;
                out_ready = 1'b0;
            end else begin
                case (mode)
                    0:       out_ready = 1'b1;
                    1:       out_ready = 1'($urandom);
                    default: out_ready = (phase_left % 3 == 0);
                endcase
            end
        end
    end

    always @(posedge clk) begin : scoreboard
        t_result want;
        if (rst_n) begin
            // check the outgoing word first: it always belongs to an older input
            if (out_valid && out_ready) begin
                results_out++;
                if (result_q.size() == 0) begin
                    $error("result word with no input pending");
                    errors++;
                end else begin
                    want = result_q.pop_front();
                    check_field("send_request", want.send, send_request);
                    check_field("request_from", want.req_lo, request_from);
                    check_field("request_to", want.req_hi, request_to);
                    check_field("miss_gap", want.gap, miss_gap);
                    check_field("miss_total", want.drops, miss_total);
                    check_field("packet_total", want.packets, packet_total);
                    check_field("counter_reset", want.went_back, counter_reset);
                    check_field("range_complete", want.filled, range_complete);
                    check_field("round_restarted", want.restarted, round_restarted);
                    check_field("backfill_active", want.active, backfill_active);
                    n_sends    += want.send;
                    n_fills    += want.filled;
                    n_restarts += want.restarted;
                    n_backs    += want.went_back;
                end
            end
            if (in_valid && in_ready) begin
                want = track_word(req_type, seq_count, delivered);
                if (row_typed) want = row_want;
                result_q.push_back(want);
                words_in++;
            end
        end
    end

    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet = 0;
        else
            quiet++;
        if (quiet == QUIET_LIMIT) begin
            $display("[sequence_gap_backfill_tracker] ERROR");
            $finish;
        end
    end

    initial begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        req_type  = REQ_LIVE;
        seq_count = '0;
        delivered = 1'b0;
        row_typed = 1'b0;
        row_want  = '0;
        cfg_we    = 1'b0;
        cfg_idx   = CFG_MAX_ATTEMPTS;
        cfg_data  = '0;
        reset_tracker();
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // first packet, repeated count, in order, gap opening a window, first request
        stim_tab.push_back(t_row'{REQ_LIVE, 31'd0, 1'b0, 1'b1,
                                  outcome(0, 0, 0, 0, 0, 1, 0, 0, 0, 0)});
        stim_tab.push_back(t_row'{REQ_LIVE, 31'd0, 1'b1, 1'b1,
                                  outcome(0, 0, 0, 0, 0, 2, 1, 0, 0, 0)});
        stim_tab.push_back(t_row'{REQ_LIVE, 31'd1, 1'b0, 1'b0, '0});
        stim_tab.push_back(t_row'{REQ_LIVE, 31'd5, 1'b0, 1'b1,
                                  outcome(0, 2, 4, 3, 3, 4, 0, 0, 0, 1)});
        stim_tab.push_back(t_row'{REQ_TICK, SEQ_MAX, 1'b1, 1'b1,
                                  outcome(1, 2, 4, 3, 3, 4, 0, 0, 0, 1)});
        // retry timer running, undelivered, marked, duplicate and outside samples
        stim_tab.push_back(t_row'{REQ_TICK, 31'd0, 1'b0, 1'b0, '0});
        stim_tab.push_back(t_row'{REQ_SAMPLE, 31'd3, 1'b0, 1'b0, '0});
        stim_tab.push_back(t_row'{REQ_SAMPLE, 31'd3, 1'b1, 1'b0, '0});
        stim_tab.push_back(t_row'{REQ_SAMPLE, 31'd3, 1'b1, 1'b0, '0});
        stim_tab.push_back(t_row'{REQ_SAMPLE, 31'd9, 1'b1, 1'b0, '0});
        // huge gap while the window is open: counted, range dropped
        stim_tab.push_back(t_row'{REQ_LIVE, 31'h7FFF_FFF0, 1'b0, 1'b0, '0});
        stim_tab.push_back(t_row'{REQ_SAMPLE, 31'd2, 1'b1, 1'b0, '0});
        stim_tab.push_back(t_row'{REQ_SAMPLE, 31'd4, 1'b1, 1'b0, '0});
        stim_tab.push_back(t_row'{REQ_SAMPLE, 31'd3, 1'b1, 1'b0, '0});
        stim_tab.push_back(t_row'{REQ_NONE, SEQ_MAX, 1'b1, 1'b0, '0});
        // window at the top of the count range, then counts going back
        stim_tab.push_back(t_row'{REQ_LIVE, SEQ_MAX, 1'b1, 1'b0, '0});
        stim_tab.push_back(t_row'{REQ_SAMPLE, 31'h7FFF_FFFE, 1'b1, 1'b0, '0});
        stim_tab.push_back(t_row'{REQ_LIVE, SEQ_MAX, 1'b0, 1'b0, '0});
        stim_tab.push_back(t_row'{REQ_LIVE, 31'd0, 1'b0, 1'b0, '0});
        stim_tab.push_back(t_row'{REQ_TICK, 31'h2AAA_AAAA, 1'b0, 1'b0, '0});
        foreach (stim_tab[i])
            send_word(stim_tab[i].kind, stim_tab[i].seq, stim_tab[i].dlv,
                      stim_tab[i].typed, stim_tab[i].want);
        run_random(150, 1'b0);

        drain();
        set_rounds(16'd1, 16'd0, 16'd0);
        run_random(180, 1'b0);

        // upper bits of the attempts word are ignored
        drain();
        set_rounds(16'hFFFF, 16'hFFFF, 16'hFFFF);
        run_random(120, 1'b0);

        drain();
        set_rounds(16'hABC0, 16'd2, 16'd1);
        run_random(180, 1'b0);

        drain();
        set_rounds(16'd3, 16'd1, 16'd3);
        write_reg(CFG_UNUSED, 16'($urandom));
        run_random(250, 1'b0);

        // windows wider than the bitmap never fill and keep cycling rounds
        drain();
        set_rounds(16'd2, 16'd4, 16'd5);
        run_random(200, 1'b1);

        drain();
        repeat (8) @(posedge clk);
        $display("Run covered %0d words and %0d results over six register settings;",
                 words_in, results_out);
        $display("%0d range requests, %0d windows filled, %0d backoffs, %0d count resets.",
                 n_sends, n_fills, n_restarts, n_backs);
        if (errors == 0)
            $display("[sequence_gap_backfill_tracker] OK");
        else
            $display("[sequence_gap_backfill_tracker] ERROR");
        $finish;
    end

endmodule
